/* rtl/http_request_header_tokenizer_core_macros.svh */
// Assertion helpers shared by the tokenizer RTL.
`ifndef HTTP_REQUEST_HEADER_TOKENIZER_CORE_MACROS_SVH
`define HTTP_REQUEST_HEADER_TOKENIZER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HRT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tokenizer check failed");

// The consequent must hold in the cycle after the antecedent.
`define HRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tokenizer check failed");

`endif

/* rtl/hrt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package hrt_pkg;

   localparam int MAX_MESSAGE     = 4096;
   localparam int HELD_SPACES_MAX = 15;
   localparam int COUNT_WIDTH     = $clog2(MAX_MESSAGE + 1);
   localparam int HELD_WIDTH      = $clog2(HELD_SPACES_MAX + 1);

   localparam int QUEUE_DEPTH       = 2;
   localparam int QUEUE_PTR_WIDTH   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   localparam logic [3:0] MATCH_POS_MAX = 4'd15;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_QMARK = 8'h3F;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;

   localparam logic [3:0] GET_LEN  = 4'd3;
   localparam logic [3:0] POST_LEN = 4'd4;
   localparam logic [3:0] HEAD_LEN = 4'd4;
   localparam logic [3:0] CONN_LEN = 4'd10;
   localparam logic [3:0] KA_LEN   = 4'd10;

   localparam logic [7:0] GET_TEXT  [0:2] = '{8'h47, 8'h45, 8'h54};
   localparam logic [7:0] POST_TEXT [0:3] = '{8'h50, 8'h4F, 8'h53, 8'h54};
   localparam logic [7:0] HEAD_TEXT [0:3] = '{8'h48, 8'h45, 8'h41, 8'h44};
   localparam logic [7:0] CONN_TEXT [0:9] = '{8'h43, 8'h6F, 8'h6E, 8'h6E, 8'h65,
                                              8'h63, 8'h74, 8'h69, 8'h6F, 8'h6E};
   localparam logic [7:0] KA_TEXT   [0:9] = '{8'h6B, 8'h65, 8'h65, 8'h70, 8'h2D,
                                              8'h61, 8'h6C, 8'h69, 8'h76, 8'h65};

   localparam logic [1:0] METHOD_UNKNOWN = 2'd0;
   localparam logic [1:0] METHOD_GET     = 2'd1;
   localparam logic [1:0] METHOD_POST    = 2'd2;
   localparam logic [1:0] METHOD_HEAD    = 2'd3;

   localparam logic [2:0] PART_METHOD  = 3'd0;
   localparam logic [2:0] PART_URL     = 3'd1;
   localparam logic [2:0] PART_QUERY   = 3'd2;
   localparam logic [2:0] PART_VERSION = 3'd3;
   localparam logic [2:0] PART_NAME    = 3'd4;
   localparam logic [2:0] PART_VALUE   = 3'd5;
   localparam logic [2:0] PART_BODY    = 3'd6;

   localparam logic [2:0] CAND_GET  = 3'b001;
   localparam logic [2:0] CAND_POST = 3'b010;
   localparam logic [2:0] CAND_HEAD = 3'b100;
   localparam logic [2:0] CAND_ALL  = 3'b111;

   typedef enum logic [6:0] {
      PH_METHOD  = 7'b0000001,
      PH_URL     = 7'b0000010,
      PH_QUERY   = 7'b0000100,
      PH_VERSION = 7'b0001000,
      PH_NAME    = 7'b0010000,
      PH_VALUE   = 7'b0100000,
      PH_BODY    = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic is_space;
      logic is_slash;
      logic is_qmark;
      logic is_colon;
      logic is_cr;
      logic is_lf;
   } byte_class_type;

   typedef struct packed {
      logic [7:0]     data;
      logic           last;
      byte_class_type cls;
   } queue_entry_type;

   function automatic logic [2:0] phase_to_part(input phase_type ph);
      logic [2:0] part;
      unique case (ph)
         PH_METHOD:  part = PART_METHOD;
         PH_URL:     part = PART_URL;
         PH_QUERY:   part = PART_QUERY;
         PH_VERSION: part = PART_VERSION;
         PH_NAME:    part = PART_NAME;
         PH_VALUE:   part = PART_VALUE;
         default:    part = PART_BODY;
      endcase
      return part;
   endfunction

   function automatic logic get_at(input logic [3:0] pos, input logic [7:0] b);
      return (pos < GET_LEN) && (GET_TEXT[pos[1:0]] == b);
   endfunction

   function automatic logic post_at(input logic [3:0] pos, input logic [7:0] b);
      return (pos < POST_LEN) && (POST_TEXT[pos[1:0]] == b);
   endfunction

   function automatic logic head_at(input logic [3:0] pos, input logic [7:0] b);
      return (pos < HEAD_LEN) && (HEAD_TEXT[pos[1:0]] == b);
   endfunction

   function automatic logic conn_at(input logic [3:0] pos, input logic [7:0] b);
      return (pos < CONN_LEN) && (CONN_TEXT[pos] == b);
   endfunction

   function automatic logic ka_at(input logic [3:0] pos, input logic [7:0] b);
      return (pos < KA_LEN) && (KA_TEXT[pos] == b);
   endfunction

endpackage

`default_nettype wire

/* rtl/hrt_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module hrt_front (
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [7:0]               req_data_byte,
   input  wire logic                     req_end_of_message,
   input  wire logic                     queue_full,
   output logic                          push,
   output hrt_pkg::queue_entry_type      push_entry
);

   hrt_pkg::byte_class_type cls;

   always_comb begin
      cls.is_space = (req_data_byte == hrt_pkg::CHAR_SPACE);
      cls.is_slash = (req_data_byte == hrt_pkg::CHAR_SLASH);
      cls.is_qmark = (req_data_byte == hrt_pkg::CHAR_QMARK);
      cls.is_colon = (req_data_byte == hrt_pkg::CHAR_COLON);
      cls.is_cr    = (req_data_byte == hrt_pkg::CHAR_CR);
      cls.is_lf    = (req_data_byte == hrt_pkg::CHAR_LF);
   end

   assign req_ready       = !queue_full;
   assign push            = req_valid && !queue_full;
   assign push_entry.data = req_data_byte;
   assign push_entry.last = req_end_of_message;
   assign push_entry.cls  = cls;

endmodule

`default_nettype wire

/* rtl/hrt_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module hrt_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire hrt_pkg::queue_entry_type push_entry,
   output logic                          full,
   input  wire logic                     pop,
   output logic                          head_valid,
   output hrt_pkg::queue_entry_type      head_entry
);

   `include "http_request_header_tokenizer_core_macros.svh"

   localparam int PW = hrt_pkg::QUEUE_PTR_WIDTH;
   localparam int CW = hrt_pkg::QUEUE_COUNT_WIDTH;

   hrt_pkg::queue_entry_type entry_ff [hrt_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
      return (p == PW'(hrt_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   assign full       = (count_ff == CW'(hrt_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `HRT_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(hrt_pkg::QUEUE_DEPTH))
   `HRT_ASSERT_NEXT(a_count_grows, clock, reset, push && !pop, count_ff == $past(count_ff) + CW'(1))

endmodule

`default_nettype wire

/* rtl/hrt_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module hrt_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_wr_en,
   input  wire logic                     csr_wr_data,
   input  wire logic                     head_valid,
   input  wire hrt_pkg::queue_entry_type head_entry,
   output logic                          pop,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [7:0]                    rsp_out_byte,
   output logic                          rsp_kept,
   output logic [2:0]                    rsp_part,
   output logic [hrt_pkg::HELD_WIDTH-1:0]  rsp_held_spaces,
   output logic                          rsp_part_end,
   output logic [1:0]                    rsp_method_code,
   output logic                          rsp_keep_alive_request,
   output logic                          rsp_headers_done,
   output logic                          rsp_message_ok,
   output logic [hrt_pkg::COUNT_WIDTH-1:0] rsp_message_length
);

   `include "http_request_header_tokenizer_core_macros.svh"

   localparam int NW = hrt_pkg::COUNT_WIDTH;
   localparam int HW = hrt_pkg::HELD_WIDTH;

   logic reuse_enable_ff;

   hrt_pkg::phase_type phase_ff, phase_in;
   logic [1:0]    term_prog_ff, term_prog_in;
   logic          term_found_ff, term_found_in;
   logic [NW-1:0] byte_count_ff, byte_count_in;
   logic [HW-1:0] pending_ff, pending_in;
   logic          value_started_ff, value_started_in;
   logic [2:0]    cand_ff, cand_in;
   logic [3:0]    match_pos_ff, match_pos_in;
   logic          name_match_ff, name_match_in;
   logic          value_match_ff, value_match_in;
   logic          token_seen_ff, token_seen_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    out_byte_ff;
   logic          kept_ff, kept_in;
   logic [2:0]    part_ff;
   logic [HW-1:0] held_ff, held_in;
   logic          pend_ff, pend_in;
   logic [1:0]    code_ff, code_in;
   logic          ka_ff, ka_in;
   logic          hdone_ff, hdone_in;
   logic          ok_ff, ok_in;
   logic [NW-1:0] len_ff, len_in;

   logic [7:0]              b;
   hrt_pkg::byte_class_type c;
   logic [3:0]              pos_adv;
   logic                    term_hit;

   assign pop          = head_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid_in = pop || (rsp_valid_ff && !rsp_ready);
   assign b            = head_entry.data;
   assign c            = head_entry.cls;
   assign pos_adv      = (match_pos_ff != hrt_pkg::MATCH_POS_MAX) ? match_pos_ff + 4'd1
                                                                   : match_pos_ff;
   assign term_hit     = term_prog_ff[0] ? c.is_lf : c.is_cr;

   always_comb begin
      phase_in         = phase_ff;
      term_prog_in     = term_prog_ff;
      term_found_in    = term_found_ff;
      byte_count_in    = byte_count_ff;
      pending_in       = pending_ff;
      value_started_in = value_started_ff;
      cand_in          = cand_ff;
      match_pos_in     = match_pos_ff;
      name_match_in    = name_match_ff;
      value_match_in   = value_match_ff;
      token_seen_in    = token_seen_ff;
      kept_in          = 1'b0;
      held_in          = '0;
      pend_in          = 1'b0;
      code_in          = hrt_pkg::METHOD_UNKNOWN;
      ka_in            = 1'b0;
      hdone_in         = 1'b0;
      ok_in            = 1'b0;
      len_in           = '0;

      if (byte_count_ff < NW'(hrt_pkg::MAX_MESSAGE)) begin
         byte_count_in = byte_count_ff + NW'(1);
      end

      // The search for CR LF CR LF runs over the whole message, across all phases.
      if (term_hit) begin
         if (term_prog_ff == 2'd3) begin
            term_found_in = 1'b1;
            term_prog_in  = 2'd2;
         end else begin
            term_prog_in = term_prog_ff + 2'd1;
         end
      end else begin
         term_prog_in = c.is_cr ? 2'd1 : 2'd0;
      end

      unique case (phase_ff)
         hrt_pkg::PH_METHOD: begin
            if (c.is_space || c.is_slash) begin
               if (token_seen_ff) begin
                  pend_in = 1'b1;
                  priority if ((cand_ff & hrt_pkg::CAND_GET) != '0
                               && match_pos_ff == hrt_pkg::GET_LEN) begin
                     code_in = hrt_pkg::METHOD_GET;
                  end else if ((cand_ff & hrt_pkg::CAND_POST) != '0
                               && match_pos_ff == hrt_pkg::POST_LEN) begin
                     code_in = hrt_pkg::METHOD_POST;
                  end else if ((cand_ff & hrt_pkg::CAND_HEAD) != '0
                               && match_pos_ff == hrt_pkg::HEAD_LEN) begin
                     code_in = hrt_pkg::METHOD_HEAD;
                  end else begin
                     code_in = hrt_pkg::METHOD_UNKNOWN;
                  end
                  phase_in      = hrt_pkg::PH_URL;
                  token_seen_in = 1'b0;
                  match_pos_in  = 4'd0;
               end
            end else begin
               kept_in       = 1'b1;
               token_seen_in = 1'b1;
               cand_in       = cand_ff;
               if (!hrt_pkg::get_at(match_pos_ff, b)) begin
                  cand_in = cand_in & ~hrt_pkg::CAND_GET;
               end
               if (!hrt_pkg::post_at(match_pos_ff, b)) begin
                  cand_in = cand_in & ~hrt_pkg::CAND_POST;
               end
               if (!hrt_pkg::head_at(match_pos_ff, b)) begin
                  cand_in = cand_in & ~hrt_pkg::CAND_HEAD;
               end
               match_pos_in = pos_adv;
            end
         end
         hrt_pkg::PH_URL: begin
            if (c.is_space) begin
               if (token_seen_ff) begin
                  pend_in       = 1'b1;
                  phase_in      = hrt_pkg::PH_VERSION;
                  token_seen_in = 1'b0;
               end
            end else if (c.is_qmark) begin
               // A query mark closes the path even when the path is empty.
               pend_in  = 1'b1;
               phase_in = hrt_pkg::PH_QUERY;
            end else begin
               kept_in       = 1'b1;
               token_seen_in = 1'b1;
            end
         end
         hrt_pkg::PH_QUERY: begin
            if (c.is_space) begin
               pend_in       = 1'b1;
               phase_in      = hrt_pkg::PH_VERSION;
               token_seen_in = 1'b0;
            end else begin
               kept_in = 1'b1;
            end
         end
         hrt_pkg::PH_VERSION: begin
            if (c.is_lf) begin
               if (token_seen_ff) begin
                  pend_in          = 1'b1;
                  phase_in         = hrt_pkg::PH_NAME;
                  pending_in       = '0;
                  value_started_in = 1'b0;
                  match_pos_in     = 4'd0;
                  name_match_in    = 1'b1;
                  value_match_in   = 1'b1;
                  token_seen_in    = 1'b0;
               end
            end else begin
               token_seen_in = 1'b1;
               kept_in       = !c.is_cr;
            end
         end
         hrt_pkg::PH_NAME: begin
            if (c.is_cr) begin
               kept_in = 1'b0;
            end else if (c.is_lf) begin
               // A line with nothing but CR bytes ends the headers.
               if (!token_seen_ff) begin
                  hdone_in = 1'b1;
                  phase_in = hrt_pkg::PH_BODY;
               end
               pending_in       = '0;
               value_started_in = 1'b0;
               match_pos_in     = 4'd0;
               name_match_in    = 1'b1;
               value_match_in   = 1'b1;
               token_seen_in    = 1'b0;
            end else if (c.is_colon) begin
               pend_in          = 1'b1;
               name_match_in    = name_match_ff && (match_pos_ff == hrt_pkg::CONN_LEN);
               pending_in       = '0;
               match_pos_in     = 4'd0;
               value_started_in = 1'b0;
               value_match_in   = 1'b1;
               phase_in         = hrt_pkg::PH_VALUE;
            end else if (c.is_space) begin
               token_seen_in = 1'b1;
               if (pending_ff < HW'(hrt_pkg::HELD_SPACES_MAX)) begin
                  pending_in = pending_ff + HW'(1);
               end
            end else begin
               kept_in       = 1'b1;
               token_seen_in = 1'b1;
               held_in       = pending_ff;
               if (pending_ff != '0 || !hrt_pkg::conn_at(match_pos_ff, b)) begin
                  name_match_in = 1'b0;
               end
               pending_in   = '0;
               match_pos_in = pos_adv;
            end
         end
         hrt_pkg::PH_VALUE: begin
            if (c.is_cr) begin
               kept_in = 1'b0;
            end else if (c.is_lf) begin
               pend_in          = 1'b1;
               ka_in            = reuse_enable_ff && name_match_ff && value_match_ff
                                  && (match_pos_ff == hrt_pkg::KA_LEN);
               phase_in         = hrt_pkg::PH_NAME;
               pending_in       = '0;
               value_started_in = 1'b0;
               match_pos_in     = 4'd0;
               name_match_in    = 1'b1;
               value_match_in   = 1'b1;
               token_seen_in    = 1'b0;
            end else if (c.is_space && !value_started_ff) begin
               kept_in = 1'b0;
            end else begin
               kept_in          = 1'b1;
               value_started_in = 1'b1;
               if (!hrt_pkg::ka_at(match_pos_ff, b)) begin
                  value_match_in = 1'b0;
               end
               match_pos_in = pos_adv;
            end
         end
         default: begin
            kept_in  = 1'b1;
            phase_in = hrt_pkg::PH_BODY;
         end
      endcase

      // The last word reports the summary and returns every parser state bit to reset.
      if (head_entry.last) begin
         ok_in            = term_found_in;
         len_in           = byte_count_in;
         phase_in         = hrt_pkg::PH_METHOD;
         term_prog_in     = 2'd0;
         term_found_in    = 1'b0;
         byte_count_in    = '0;
         cand_in          = hrt_pkg::CAND_ALL;
         pending_in       = '0;
         value_started_in = 1'b0;
         match_pos_in     = 4'd0;
         name_match_in    = 1'b1;
         value_match_in   = 1'b1;
         token_seen_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reuse_enable_ff <= 1'b0;
      end else if (csr_wr_en) begin
         reuse_enable_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff     <= 1'b0;
         phase_ff         <= hrt_pkg::PH_METHOD;
         term_prog_ff     <= 2'd0;
         term_found_ff    <= 1'b0;
         byte_count_ff    <= '0;
         pending_ff       <= '0;
         value_started_ff <= 1'b0;
         cand_ff          <= hrt_pkg::CAND_ALL;
         match_pos_ff     <= 4'd0;
         name_match_ff    <= 1'b1;
         value_match_ff   <= 1'b1;
         token_seen_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            phase_ff         <= phase_in;
            term_prog_ff     <= term_prog_in;
            term_found_ff    <= term_found_in;
            byte_count_ff    <= byte_count_in;
            pending_ff       <= pending_in;
            value_started_ff <= value_started_in;
            cand_ff          <= cand_in;
            match_pos_ff     <= match_pos_in;
            name_match_ff    <= name_match_in;
            value_match_ff   <= value_match_in;
            token_seen_ff    <= token_seen_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_byte_ff <= b;
         kept_ff     <= kept_in;
         part_ff     <= hrt_pkg::phase_to_part(phase_ff);
         held_ff     <= held_in;
         pend_ff     <= pend_in;
         code_ff     <= code_in;
         ka_ff       <= ka_in;
         hdone_ff    <= hdone_in;
         ok_ff       <= ok_in;
         len_ff      <= len_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_out_byte           = out_byte_ff;
   assign rsp_kept               = kept_ff;
   assign rsp_part               = part_ff;
   assign rsp_held_spaces        = held_ff;
   assign rsp_part_end           = pend_ff;
   assign rsp_method_code        = code_ff;
   assign rsp_keep_alive_request = ka_ff;
   assign rsp_headers_done       = hdone_ff;
   assign rsp_message_ok         = ok_ff;
   assign rsp_message_length     = len_ff;

   `HRT_ASSERT_NEXT(a_last_restarts, clock, reset, pop && head_entry.last, phase_ff == hrt_pkg::PH_METHOD && byte_count_ff == '0)
   `HRT_ASSERT_SAME(a_held_on_name, clock, reset, rsp_valid_ff && held_ff != '0, kept_ff && part_ff == hrt_pkg::PART_NAME)

endmodule

`default_nettype wire

/* rtl/http_request_header_tokenizer_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Word
// req       in         req_valid/req_ready  one message byte, last-byte flag
// rsp       out        rsp_valid/rsp_ready  the byte with its tag and summary fields
// csr       in         csr_wr_en            connection reuse enable bit, no read-back
//
// One byte per cycle while rsp_ready holds; a taken byte is registered in the queue and then
// in the output register. The parser state update in the back end is the only per-byte loop.
// A two-word queue splits the classifier from the parser, so req stays ready while one
// result waits on a stalled rsp; req_ready drops once the queue is full.
// Reset is synchronous and active high and leaves the parser at the start of a message.

module http_request_header_tokenizer_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic                          csr_wr_data,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [7:0]                    req_data_byte,
   input  wire logic                          req_end_of_message,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [7:0]                         rsp_out_byte,
   output logic                               rsp_kept,
   output logic [2:0]                         rsp_part,
   output logic [hrt_pkg::HELD_WIDTH-1:0]     rsp_held_spaces,
   output logic                               rsp_part_end,
   output logic [1:0]                         rsp_method_code,
   output logic                               rsp_keep_alive_request,
   output logic                               rsp_headers_done,
   output logic                               rsp_message_ok,
   output logic [hrt_pkg::COUNT_WIDTH-1:0]    rsp_message_length
);

   logic                     queue_full;
   logic                     push;
   hrt_pkg::queue_entry_type push_entry;
   logic                     pop;
   logic                     head_valid;
   hrt_pkg::queue_entry_type head_entry;

   hrt_front u_front (
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_end_of_message (req_end_of_message),
      .queue_full         (queue_full),
      .push               (push),
      .push_entry         (push_entry)
   );

   hrt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   hrt_back u_back (
      .clock                  (clock),
      .reset                  (reset),
      .csr_wr_en              (csr_wr_en),
      .csr_wr_data            (csr_wr_data),
      .head_valid             (head_valid),
      .head_entry             (head_entry),
      .pop                    (pop),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_out_byte           (rsp_out_byte),
      .rsp_kept               (rsp_kept),
      .rsp_part               (rsp_part),
      .rsp_held_spaces        (rsp_held_spaces),
      .rsp_part_end           (rsp_part_end),
      .rsp_method_code        (rsp_method_code),
      .rsp_keep_alive_request (rsp_keep_alive_request),
      .rsp_headers_done       (rsp_headers_done),
      .rsp_message_ok         (rsp_message_ok),
      .rsp_message_length     (rsp_message_length)
   );

endmodule

`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;

   localparam int LIMIT_CYCLES = 200000;
   localparam int HW = hrt_pkg::HELD_WIDTH;
   localparam int NW = hrt_pkg::COUNT_WIDTH;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } word_type;

   typedef struct packed {
      logic [7:0]    data;
      logic          kept;
      logic [2:0]    part;
      logic [HW-1:0] held;
      logic          part_end;
      logic [1:0]    method;
      logic          conn_reuse;
      logic          hdr_done;
      logic          msg_ok;
      logic [NW-1:0] msg_len;
   } tag_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic csr_wr_data = 1'b0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_data_byte = 8'h00;
   logic req_end_of_message = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic rsp_kept;
   logic [2:0] rsp_part;
   logic [HW-1:0] rsp_held_spaces;
   logic rsp_part_end;
   logic [1:0] rsp_method_code;
   logic rsp_keep_alive_request;
   logic rsp_headers_done;
   logic rsp_message_ok;
   logic [NW-1:0] rsp_message_length;

   http_request_header_tokenizer_core dut (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data_byte(req_data_byte),
      .req_end_of_message(req_end_of_message),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_byte(rsp_out_byte),
      .rsp_kept(rsp_kept),
      .rsp_part(rsp_part),
      .rsp_held_spaces(rsp_held_spaces),
      .rsp_part_end(rsp_part_end),
      .rsp_method_code(rsp_method_code),
      .rsp_keep_alive_request(rsp_keep_alive_request),
      .rsp_headers_done(rsp_headers_done),
      .rsp_message_ok(rsp_message_ok),
      .rsp_message_length(rsp_message_length)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   word_type pending_words[$];
   tag_type expected_tags[$];
   logic [7:0] msg_buf[$];
   int error_count = 0;
   int send_idle_pct = 33;
   int recv_idle_pct = 68;
   bit hold_sender = 1'b0;
   bit req_taken = 1'b0;
   int cycle_count = 0;

   // Tokenizer state as the predictor sees it.
   logic [2:0]    tk_part;
   logic [1:0]    crlf_prog;
   logic          crlf_seen;
   logic [NW-1:0] msg_count;
   logic [HW-1:0] space_run;
   logic          value_begun;
   logic [2:0]    method_cands;
   logic [3:0]    match_pos;
   logic          name_is_conn;
   logic          value_is_ka;
   logic          token_begun;
   logic          reuse_enable;

   function automatic void restart_line();
      space_run = '0;
      value_begun = 1'b0;
      match_pos = 4'd0;
      name_is_conn = 1'b1;
      value_is_ka = 1'b1;
      token_begun = 1'b0;
   endfunction

   function automatic void restart_message();
      tk_part = hrt_pkg::PART_METHOD;
      crlf_prog = 2'd0;
      crlf_seen = 1'b0;
      msg_count = '0;
      method_cands = hrt_pkg::CAND_ALL;
      restart_line();
   endfunction

   function automatic void bump_pos();
      if (match_pos != hrt_pkg::MATCH_POS_MAX) match_pos++;
   endfunction

   function automatic logic text_hit(string s, logic [3:0] pos, logic [7:0] b);
      if (int'(pos) >= s.len()) return 1'b0;
      return 8'(s.getc(int'(pos))) == b;
   endfunction

   function automatic tag_type tokenize_word(input logic [7:0] b, input logic last);
      tag_type t;
      logic [7:0] crlf_next;
      t = '0;
      t.data = b;
      t.part = tk_part;
      if (msg_count < hrt_pkg::MAX_MESSAGE) msg_count++;

      // Running search for CR LF CR LF; a CR after CR LF CR restarts at one.
      crlf_next = crlf_prog[0] ? hrt_pkg::CHAR_LF : hrt_pkg::CHAR_CR;
      if (b == crlf_next) begin
         if (crlf_prog == 2'd3) begin
            crlf_seen = 1'b1;
            crlf_prog = 2'd2;
         end else begin
            crlf_prog++;
         end
      end else begin
         crlf_prog = (b == hrt_pkg::CHAR_CR) ? 2'd1 : 2'd0;
      end

      case (tk_part)
         hrt_pkg::PART_METHOD: begin
            if (b == hrt_pkg::CHAR_SPACE || b == hrt_pkg::CHAR_SLASH) begin
               if (token_begun) begin
                  t.part_end = 1'b1;
                  if ((method_cands & hrt_pkg::CAND_GET) != 0 && match_pos == 4'd3)
                     t.method = hrt_pkg::METHOD_GET;
                  else if ((method_cands & hrt_pkg::CAND_POST) != 0 && match_pos == 4'd4)
                     t.method = hrt_pkg::METHOD_POST;
                  else if ((method_cands & hrt_pkg::CAND_HEAD) != 0 && match_pos == 4'd4)
                     t.method = hrt_pkg::METHOD_HEAD;
                  tk_part = hrt_pkg::PART_URL;
                  token_begun = 1'b0;
                  match_pos = 4'd0;
               end
            end else begin
               t.kept = 1'b1;
               token_begun = 1'b1;
               if (!text_hit("GET", match_pos, b)) method_cands &= ~hrt_pkg::CAND_GET;
               if (!text_hit("POST", match_pos, b)) method_cands &= ~hrt_pkg::CAND_POST;
               if (!text_hit("HEAD", match_pos, b)) method_cands &= ~hrt_pkg::CAND_HEAD;
               bump_pos();
            end
         end
         hrt_pkg::PART_URL: begin
            if (b == hrt_pkg::CHAR_SPACE) begin
               if (token_begun) begin
                  t.part_end = 1'b1;
                  tk_part = hrt_pkg::PART_VERSION;
                  token_begun = 1'b0;
               end
            end else if (b == hrt_pkg::CHAR_QMARK) begin
               t.part_end = 1'b1;
               tk_part = hrt_pkg::PART_QUERY;
            end else begin
               t.kept = 1'b1;
               token_begun = 1'b1;
            end
         end
         hrt_pkg::PART_QUERY: begin
            if (b == hrt_pkg::CHAR_SPACE) begin
               t.part_end = 1'b1;
               tk_part = hrt_pkg::PART_VERSION;
               token_begun = 1'b0;
            end else begin
               t.kept = 1'b1;
            end
         end
         hrt_pkg::PART_VERSION: begin
            if (b == hrt_pkg::CHAR_LF) begin
               if (token_begun) begin
                  t.part_end = 1'b1;
                  tk_part = hrt_pkg::PART_NAME;
                  restart_line();
               end
            end else begin
               token_begun = 1'b1;
               t.kept = (b != hrt_pkg::CHAR_CR);
            end
         end
         hrt_pkg::PART_NAME: begin
            if (b == hrt_pkg::CHAR_CR) begin
            end else if (b == hrt_pkg::CHAR_LF) begin
               if (!token_begun) begin
                  t.hdr_done = 1'b1;
                  tk_part = hrt_pkg::PART_BODY;
               end
               restart_line();
            end else if (b == hrt_pkg::CHAR_COLON) begin
               t.part_end = 1'b1;
               name_is_conn = name_is_conn && (match_pos == 4'd10);
               space_run = '0;
               match_pos = 4'd0;
               value_begun = 1'b0;
               value_is_ka = 1'b1;
               tk_part = hrt_pkg::PART_VALUE;
            end else if (b == hrt_pkg::CHAR_SPACE) begin
               token_begun = 1'b1;
               if (space_run < HW'(hrt_pkg::HELD_SPACES_MAX)) space_run++;
            end else begin
               t.kept = 1'b1;
               token_begun = 1'b1;
               t.held = space_run;
               if (space_run != 0 || !text_hit("Connection", match_pos, b))
                  name_is_conn = 1'b0;
               space_run = '0;
               bump_pos();
            end
         end
         hrt_pkg::PART_VALUE: begin
            if (b == hrt_pkg::CHAR_CR) begin
            end else if (b == hrt_pkg::CHAR_LF) begin
               t.part_end = 1'b1;
               t.conn_reuse = reuse_enable && name_is_conn && value_is_ka
                              && match_pos == 4'd10;
               tk_part = hrt_pkg::PART_NAME;
               restart_line();
            end else if (b == hrt_pkg::CHAR_SPACE && !value_begun) begin
            end else begin
               t.kept = 1'b1;
               value_begun = 1'b1;
               if (!text_hit("keep-alive", match_pos, b)) value_is_ka = 1'b0;
               bump_pos();
            end
         end
         default: begin
            t.kept = 1'b1;
            tk_part = hrt_pkg::PART_BODY;
            t.part = hrt_pkg::PART_BODY;
         end
      endcase

      if (last) begin
         t.msg_ok = crlf_seen;
         t.msg_len = msg_count;
         restart_message();
      end
      return t;
   endfunction

   // Message construction into msg_buf.
   function automatic void put_text(string s);
      for (int i = 0; i < s.len(); i++) msg_buf.push_back(8'(s.getc(i)));
   endfunction

   function automatic logic [7:0] token_char();
      int r;
      r = $urandom_range(9);
      if (r < 5) return 8'(8'h61 + $urandom_range(25));
      if (r < 8) return 8'(8'h41 + $urandom_range(25));
      if (r == 8) return 8'(8'h30 + $urandom_range(9));
      return 8'h2D;
   endfunction

   function automatic void put_token(int n);
      repeat (n) msg_buf.push_back(token_char());
   endfunction

   function automatic void put_eol();
      if ($urandom_range(5) != 0) msg_buf.push_back(hrt_pkg::CHAR_CR);
      msg_buf.push_back(hrt_pkg::CHAR_LF);
   endfunction

   function automatic void put_spaces(int n);
      repeat (n) msg_buf.push_back(hrt_pkg::CHAR_SPACE);
   endfunction

   function automatic string method_text();
      case ($urandom_range(8))
         0: return "GET";
         1: return "POST";
         2: return "HEAD";
         3: return "GE";
         4: return "GETS";
         5: return "PUT";
         6: return "HEA";
         7: return "POSTS";
         default: return "get";
      endcase
   endfunction

   function automatic string name_text();
      case ($urandom_range(8))
         0, 1, 2, 3: return "Connection";
         4: return "connection";
         5: return "Connectio";
         6: return "Connections";
         7: return "Host";
         default: return "Conn ection";
      endcase
   endfunction

   function automatic string value_text();
      case ($urandom_range(9))
         0, 1, 2, 3: return "keep-alive";
         4: return "keep-alive ";
         5: return "Keep-Alive";
         6: return "keep-aliv";
         7: return "keep-alivee";
         8: return "close";
         default: return "keep alive";
      endcase
   endfunction

   function automatic void put_header_line();
      if ($urandom_range(7) == 0) put_spaces(1);
      if ($urandom_range(5) == 0) put_token($urandom_range(6, 1));
      else put_text(name_text());
      // Inner space runs show up as held spaces on the next name byte.
      if ($urandom_range(4) == 0) begin
         if ($urandom_range(2) == 0) put_spaces($urandom_range(20, 14));
         else put_spaces($urandom_range(3, 1));
         put_token($urandom_range(2, 1));
      end
      put_spaces($urandom_range(3) == 0 ? $urandom_range(2, 1) : 0);
      if ($urandom_range(7) != 0) begin
         msg_buf.push_back(hrt_pkg::CHAR_COLON);
         put_spaces($urandom_range(3));
         if ($urandom_range(5) == 0) put_token($urandom_range(8));
         else put_text(value_text());
      end
      put_eol();
   endfunction

   function automatic void build_request();
      int n;
      msg_buf.delete();
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(20, 3)) msg_buf.push_back(8'($urandom_range(255)));
      end else begin
         if ($urandom_range(5) == 0) begin
            repeat ($urandom_range(2, 1))
               msg_buf.push_back($urandom_range(1) ? hrt_pkg::CHAR_SPACE
                                                   : hrt_pkg::CHAR_SLASH);
         end
         if ($urandom_range(7) == 0) put_token($urandom_range(5, 1));
         else put_text(method_text());
         msg_buf.push_back($urandom_range(1) ? hrt_pkg::CHAR_SPACE : hrt_pkg::CHAR_SLASH);
         if ($urandom_range(5) == 0) put_spaces(1);
         put_token($urandom_range(6));
         if ($urandom_range(1)) begin
            msg_buf.push_back(hrt_pkg::CHAR_QMARK);
            put_token($urandom_range(5));
         end
         msg_buf.push_back(hrt_pkg::CHAR_SPACE);
         if ($urandom_range(7) == 0) msg_buf.push_back(hrt_pkg::CHAR_LF);
         put_text($urandom_range(3) == 0 ? "V" : "HTTP/1.1");
         put_eol();
         repeat ($urandom_range(3)) put_header_line();
         if ($urandom_range(9) != 0) put_eol();
         repeat ($urandom_range(6)) msg_buf.push_back(8'($urandom_range(255)));
      end
      if ($urandom_range(7) == 0)
         msg_buf[$urandom_range(msg_buf.size() - 1)] = 8'($urandom_range(255));
      if ($urandom_range(9) == 0) begin
         n = $urandom_range(msg_buf.size(), 1);
         while (msg_buf.size() > n) void'(msg_buf.pop_back());
      end
   endfunction

   function automatic int queue_message();
      word_type w;
      foreach (msg_buf[i]) begin
         w.data = msg_buf[i];
         w.last = (i == msg_buf.size() - 1);
         pending_words.push_back(w);
      end
      return msg_buf.size();
   endfunction

   task automatic fill_requests(input int n_words);
      int queued;
      queued = 0;
      while (queued < n_words) begin
         build_request();
         queued += queue_message();
      end
   endtask

   task automatic set_reuse_enable(input logic v);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      reuse_enable = v;
   endtask

   task automatic drain();
      while (pending_words.size() != 0 || req_valid || expected_tags.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: %s mismatch: got %0h expected %0h", $realtime, what, got, want);
      error_count++;
   endtask

   // Driver: new words are offered at the falling edge only after the last one was taken.
   always @(negedge clock) begin : drive_words
      word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (!hold_sender && pending_words.size() != 0 &&
             $urandom_range(99) >= send_idle_pct) begin
            w = pending_words.pop_front();
            req_valid <= 1'b1;
            req_data_byte <= w.data;
            req_end_of_message <= w.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // Monitor: check results first, then predict the word taken at this edge.
   always @(posedge clock) begin : check_words
      tag_type want;
      req_taken = !reset && req_valid && req_ready;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_tags.size() == 0) begin
            report_mismatch("unexpected word", rsp_out_byte, 0);
         end else begin
            want = expected_tags.pop_front();
            if (rsp_out_byte !== want.data) report_mismatch("out_byte", rsp_out_byte, want.data);
            if (rsp_kept !== want.kept) report_mismatch("kept", rsp_kept, want.kept);
            if (rsp_part !== want.part) report_mismatch("part", rsp_part, want.part);
            if (rsp_held_spaces !== want.held)
               report_mismatch("held_spaces", rsp_held_spaces, want.held);
            if (rsp_part_end !== want.part_end)
               report_mismatch("part_end", rsp_part_end, want.part_end);
            if (rsp_method_code !== want.method)
               report_mismatch("method_code", rsp_method_code, want.method);
            if (rsp_keep_alive_request !== want.conn_reuse)
               report_mismatch("keep_alive_request", rsp_keep_alive_request, want.conn_reuse);
            if (rsp_headers_done !== want.hdr_done)
               report_mismatch("headers_done", rsp_headers_done, want.hdr_done);
            if (rsp_message_ok !== want.msg_ok)
               report_mismatch("message_ok", rsp_message_ok, want.msg_ok);
            if (rsp_message_length !== want.msg_len)
               report_mismatch("message_length", rsp_message_length, want.msg_len);
         end
      end
      if (req_taken) expected_tags.push_back(tokenize_word(req_data_byte, req_end_of_message));
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("http_request_header_tokenizer_core verification failed");
         $finish;
      end
   end

   initial begin : run_test
      int n;
      reuse_enable = 1'b0;
      restart_message();
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Directed: leading delimiters, empty path, leading version LF, empty line, zero byte.
      set_reuse_enable(1'b1);
      msg_buf.delete();
      msg_buf.push_back(hrt_pkg::CHAR_SPACE);
      msg_buf.push_back(hrt_pkg::CHAR_SLASH);
      put_text("POST");
      put_spaces(2);
      msg_buf.push_back(hrt_pkg::CHAR_QMARK);
      put_text("q");
      put_spaces(1);
      msg_buf.push_back(hrt_pkg::CHAR_LF);
      put_text("V");
      msg_buf.push_back(hrt_pkg::CHAR_LF);
      msg_buf.push_back(hrt_pkg::CHAR_LF);
      msg_buf.push_back(8'hFF);
      n = queue_message();
      msg_buf.delete();
      msg_buf.push_back(8'h00);
      n = queue_message();
      msg_buf.delete();
      put_text("HEAD/");
      n = queue_message();
      drain();

      set_reuse_enable(1'b0);
      fill_requests(420);
      while (pending_words.size() > 210) @(posedge clock);
      hold_sender = 1'b1;
      while (req_valid || expected_tags.size() != 0) @(posedge clock);
      hold_sender = 1'b0;
      drain();

      send_idle_pct = 68;
      recv_idle_pct = 33;
      set_reuse_enable(1'b1);
      fill_requests(420);
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_reuse_enable(1'b0);
      fill_requests(210);
      drain();
      set_reuse_enable(1'b1);
      fill_requests(210);
      drain();
      repeat (10) @(posedge clock);

      if (error_count == 0) begin
         $display("http_request_header_tokenizer_core verification clean");
      end else begin
         $display("http_request_header_tokenizer_core verification failed");
      end
      $finish;
   end

endmodule
